// ----- hdl/cdscf_pkg.sv -----
// Shared types and constants for the sector cache fill controller.
// Used by every module of the block except cdscf_ram; no dependencies.
package cdscf_pkg;

    localparam int CACHE_SLOTS_DEF = 256;
    localparam int INDEX_DEPTH_DEF = 4096;

    localparam int LBA_W      = 19;
    localparam int OFF_W      = 12;
    localparam int SEEK_W     = 13;
    localparam int EXP_W      = 20;
    localparam int RETRY_W    = 16;
    localparam int SLOT_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 19;
    localparam int S_TDATA_W  = 24;
    localparam int S_TUSER_W  = 2;
    localparam int M_TDATA_W  = 56;

    typedef enum logic [1:0] {
        CMD_START    = 2'd0,
        CMD_SECTOR   = 2'd1,
        CMD_DISK_ERR = 2'd2,
        CMD_OTHER    = 2'd3
    } cmd_code_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_OFFSET    = 3'd1,
        ERR_READ      = 3'd2,
        ERR_DISK      = 3'd3,
        ERR_UNKNOWN   = 3'd4,
        ERR_FULL      = 3'd5
    } err_t;

    typedef enum logic [1:0] {
        CFG_FILE_START   = 2'd0,
        CFG_FIRST_SECTOR = 2'd1,
        CFG_LAST_SECTOR  = 2'd2,
        CFG_MAX_SECTOR   = 2'd3
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL,
        ST_LOOK,
        ST_SCAN,
        ST_ADV,
        ST_EMIT
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic clear_wr;
        logic load;
        logic start;
        logic retry_inc;
        logic retry_clr;
        logic err_set;
        err_t err;
        logic scan_init;
        logic rd_next;
        logic store;
        logic scan_adv;
        logic seek_scan;
        logic seek_adv;
        logic emit;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic      clear_last;
        cmd_code_t icmd;
        logic      done;
        logic      full;
        logic      read_ok;
        logic      match;
        logic      off_bad;
        logic      rdata_zero;
        logic      scan_stop;
        logic      off_eq_seek;
        logic      out_free;
    } ctrl_sts_t;

endpackage

// ----- hdl/cd_sector_cache_fill.sv -----
// Top level of the sector cache fill controller.
// Depends on cdscf_pkg, cdscf_ctrl, cdscf_dp (which holds the cdscf_ram index map).
//
// Takes one item at a time. After reset the offset-to-slot index RAM is zeroed, one
// entry per cycle; s_tready stays low during that pass but config writes are taken.
// A start, status, mismatch or rejected sector item passes through the EVAL and EMIT
// states before m_tvalid; a newly stored sector through EVAL, LOOK, ADV and EMIT.
// A sector whose offset is already cached walks the index RAM one entry per cycle
// (LOOK, then SCAN) up to the first uncached offset or last_sector, then goes
// through ADV and EMIT. Slots are handed out in order from 1, so the next free slot
// is one more than the number of slots filled. The output register holds one result;
// the block waits for it to be taken before finishing the next item.
module cd_sector_cache_fill #(
    parameter int CACHE_SLOTS = cdscf_pkg::CACHE_SLOTS_DEF,
    parameter int INDEX_DEPTH = cdscf_pkg::INDEX_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [cdscf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cdscf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [cdscf_pkg::S_TDATA_W-1:0]  s_tdata,  // sector_lba[18:0], read_ok[19]
    input  logic [cdscf_pkg::S_TUSER_W-1:0]  s_tuser,  // cmd[1:0]
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // store_slot[7:0], read_request[8], next_sector[28:9], file_done[29],
    // retry_count[45:30], error_code[48:46]
    output logic [cdscf_pkg::M_TDATA_W-1:0]  m_tdata
);

    import cdscf_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    cdscf_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cdscf_dp #(
        .CACHE_SLOTS (CACHE_SLOTS),
        .INDEX_DEPTH (INDEX_DEPTH)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

// ----- hdl/cdscf_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module cdscf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hdl/cdscf_ctrl.sv -----
// Controller state machine for the sector cache fill block.
// Depends on cdscf_pkg; drives the datapath through ctrl_cmd_t.
module cdscf_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  cdscf_pkg::ctrl_sts_t sts,
    output cdscf_pkg::ctrl_cmd_t cmd
);

    import cdscf_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.err    = ERR_NONE;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_wr = 1'b1;
                if (sts.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_EVAL;
                end
            end
            ST_EVAL: begin
                state_next = ST_EMIT;
                if (sts.icmd == CMD_START) begin
                    cmd.start = 1'b1;
                end else if (!sts.done) begin
                    unique case (sts.icmd)
                        CMD_DISK_ERR: begin
                            cmd.err_set = 1'b1;
                            cmd.err     = ERR_DISK;
                            cmd.start   = 1'b1;
                        end
                        CMD_OTHER: begin
                            cmd.err_set = 1'b1;
                            cmd.err     = ERR_UNKNOWN;
                            cmd.start   = 1'b1;
                        end
                        default: begin
                            if (sts.full) begin
                                cmd.retry_clr = 1'b1;
                                cmd.err_set   = 1'b1;
                                cmd.err       = ERR_FULL;
                                cmd.start     = 1'b1;
                            end else if (!sts.read_ok) begin
                                cmd.err_set = 1'b1;
                                cmd.err     = ERR_READ;
                                cmd.start   = 1'b1;
                            end else if (!sts.match) begin
                                cmd.retry_inc = 1'b1;
                                cmd.start     = 1'b1;
                            end else if (sts.off_bad) begin
                                cmd.retry_clr = 1'b1;
                                cmd.err_set   = 1'b1;
                                cmd.err       = ERR_OFFSET;
                                cmd.start     = 1'b1;
                            end else begin
                                cmd.retry_clr = 1'b1;
                                cmd.scan_init = 1'b1;
                                state_next    = ST_LOOK;
                            end
                        end
                    endcase
                end
            end
            ST_LOOK, ST_SCAN: begin
                if (state_reg == ST_LOOK && sts.rdata_zero) begin
                    cmd.store  = 1'b1;
                    state_next = ST_ADV;
                end else if (sts.scan_stop) begin
                    cmd.seek_scan = 1'b1;
                    state_next    = ST_ADV;
                end else begin
                    cmd.scan_adv = 1'b1;
                    cmd.rd_next  = 1'b1;
                    state_next   = ST_SCAN;
                end
            end
            ST_ADV: begin
                state_next = ST_EMIT;
                if (sts.off_eq_seek) begin
                    cmd.seek_adv = 1'b1;
                end else if (!sts.done) begin
                    cmd.start = 1'b1;
                end
            end
            ST_EMIT: begin
                if (sts.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/cdscf_dp.sv -----
// Datapath: config and stream registers, offset-to-slot index RAM, output register.
// Depends on cdscf_pkg and cdscf_ram; steered by cdscf_ctrl.
module cdscf_dp #(
    parameter int CACHE_SLOTS = cdscf_pkg::CACHE_SLOTS_DEF,
    parameter int INDEX_DEPTH = cdscf_pkg::INDEX_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_wr_en,
    input  logic [cdscf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [cdscf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic [cdscf_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [cdscf_pkg::S_TUSER_W-1:0]  s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [cdscf_pkg::M_TDATA_W-1:0]  m_tdata,
    input  cdscf_pkg::ctrl_cmd_t             cmd,
    output cdscf_pkg::ctrl_sts_t             sts
);

    import cdscf_pkg::*;

    localparam int AW    = $clog2(INDEX_DEPTH);
    localparam int CNT_W = $clog2(CACHE_SLOTS + 1);

    logic [LBA_W-1:0]   file_start_reg;
    logic [OFF_W-1:0]   first_reg, last_reg, max_reg;
    logic [SEEK_W-1:0]  seek_reg;
    logic [EXP_W-1:0]   expected_reg;
    logic [RETRY_W-1:0] retries_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   used_reg;

    cmd_code_t          icmd_reg;
    logic [LBA_W-1:0]   lba_reg;
    logic               ok_reg;
    logic [SEEK_W-1:0]  chk_reg;
    logic [SLOT_W-1:0]  store_reg;
    logic               req_reg;
    err_t               err_reg;
    logic [AW-1:0]      clr_reg;
    logic               mvalid_reg;
    logic [M_TDATA_W-1:0] mdata_reg;

    logic [OFF_W-1:0]   last_clamp;
    logic [SEEK_W-1:0]  seek_win, seek_inc;
    logic [EXP_W-1:0]   exp_start, exp_inc;
    logic [LBA_W-1:0]   off_full;
    logic [OFF_W-1:0]   off;
    logic               off_bad;
    logic [SEEK_W-1:0]  chk_inc;
    logic               chk_in_range, chk_past;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [SLOT_W-1:0]  ram_wdata, ram_rdata;

    // stream (re)start
    assign last_clamp = (last_reg > max_reg) ? max_reg : last_reg;
    assign seek_win   = (seek_reg < {1'b0, first_reg} || seek_reg > {1'b0, last_clamp}) ?
                        {1'b0, first_reg} : seek_reg;
    assign exp_start  = {1'b0, file_start_reg} + EXP_W'(seek_win);

    assign seek_inc   = seek_reg + 1'b1;
    assign exp_inc    = {1'b0, file_start_reg} + EXP_W'(seek_inc);

    assign off_full   = lba_reg - file_start_reg;
    assign off        = off_full[OFF_W-1:0];
    assign off_bad    = (lba_reg < file_start_reg) || (off_full > LBA_W'(max_reg)) ||
                        (32'(off_full) >= INDEX_DEPTH);

    assign chk_inc      = chk_reg + 1'b1;
    assign chk_in_range = 32'(chk_reg) < INDEX_DEPTH;
    assign chk_past     = chk_reg > {1'b0, last_reg};

    assign ram_we    = cmd.clear_wr | cmd.store;
    assign ram_waddr = cmd.clear_wr ? clr_reg : AW'(off);
    assign ram_wdata = cmd.clear_wr ? '0 : SLOT_W'(used_reg);
    assign ram_raddr = cmd.rd_next ? AW'(chk_inc) : AW'(off);

    cdscf_ram #(
        .WIDTH (SLOT_W),
        .DEPTH (INDEX_DEPTH)
    ) u_index_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            file_start_reg <= '0;
            first_reg      <= '0;
            last_reg       <= '0;
            max_reg        <= '0;
            seek_reg       <= '0;
            expected_reg   <= '0;
            retries_reg    <= '0;
            done_reg       <= 1'b1;
            used_reg       <= CNT_W'(1);
            clr_reg        <= '0;
            mvalid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                unique case (cfg_idx_t'(cfg_index))
                    CFG_FILE_START:   file_start_reg <= cfg_wdata[LBA_W-1:0];
                    CFG_FIRST_SECTOR: first_reg      <= cfg_wdata[OFF_W-1:0];
                    CFG_LAST_SECTOR:  last_reg       <= cfg_wdata[OFF_W-1:0];
                    CFG_MAX_SECTOR:   max_reg        <= cfg_wdata[OFF_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.clear_wr) begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cmd.start) begin
                done_reg     <= 1'b0;
                last_reg     <= last_clamp;
                seek_reg     <= seek_win;
                expected_reg <= exp_start;
            end
            if (cmd.retry_clr) begin
                retries_reg <= '0;
            end else if (cmd.retry_inc && retries_reg != '1) begin
                retries_reg <= retries_reg + 1'b1;
            end
            if (cmd.store) begin
                used_reg <= used_reg + 1'b1;
            end
            if (cmd.seek_scan) begin
                seek_reg <= chk_reg;
                if (chk_past) begin
                    done_reg <= 1'b1;
                end
            end
            if (cmd.seek_adv) begin
                seek_reg <= seek_inc;
                if (seek_inc > {1'b0, last_reg}) begin
                    done_reg <= 1'b1;
                end else begin
                    expected_reg <= exp_inc;
                end
            end
            if (cmd.emit) begin
                mvalid_reg <= 1'b1;
            end else if (m_tready) begin
                mvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            icmd_reg  <= cmd_code_t'(s_tuser);
            lba_reg   <= s_tdata[LBA_W-1:0];
            ok_reg    <= s_tdata[LBA_W];
            store_reg <= '0;
            req_reg   <= 1'b0;
            err_reg   <= ERR_NONE;
        end
        if (cmd.start) begin
            req_reg <= 1'b1;
        end
        if (cmd.err_set) begin
            err_reg <= cmd.err;
        end
        if (cmd.store) begin
            store_reg <= SLOT_W'(used_reg);
        end
        if (cmd.scan_init) begin
            chk_reg <= {1'b0, off};
        end else if (cmd.scan_adv) begin
            chk_reg <= chk_inc;
        end
        if (cmd.emit) begin
            mdata_reg <= {7'd0, err_reg, retries_reg, done_reg, expected_reg,
                          req_reg, store_reg};
        end
    end

    always_comb begin
        sts.clear_last  = (clr_reg == AW'(INDEX_DEPTH - 1));
        sts.icmd        = icmd_reg;
        sts.done        = done_reg;
        sts.full        = 32'(used_reg) >= CACHE_SLOTS;
        sts.read_ok     = ok_reg;
        sts.match       = ({1'b0, lba_reg} == expected_reg);
        sts.off_bad     = off_bad;
        sts.rdata_zero  = (ram_rdata == '0);
        sts.scan_stop   = chk_past || !chk_in_range || (ram_rdata == '0);
        sts.off_eq_seek = ({1'b0, off} == seek_reg);
        sts.out_free    = !mvalid_reg || m_tready;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = mdata_reg;

endmodule

// ----- verif/cd_sector_cache_fill_tb.sv -----
// Self-checking testbench for the sector cache fill controller (cd_sector_cache_fill).
// Drives stream items and register writes, predicts every result in-bench and scoreboards
// m_tdata field by field. Depends on cdscf_pkg and the RTL under hdl/.
`timescale 1ns / 1ps

module cd_sector_cache_fill_tb;
    import cdscf_pkg::*;

    typedef struct packed {
        logic [7:0]  slot;
        logic        req;
        logic [19:0] next;
        logic        done;
        logic [15:0] retry;
        err_t        err;
    } fill_result_t;

    // directed plan: a register write or an item, with optional hand-typed outcome
    typedef struct packed {
        logic        is_cfg;
        cfg_idx_t    sel;
        logic [18:0] value;
        cmd_code_t   cmd;
        logic [18:0] lba;
        logic        ok;
        logic        typed;
        logic        req;
        logic        done;
        err_t        err;
    } plan_row_t;

    localparam int PLAN_LEN = 25;

    plan_row_t plan [PLAN_LEN] = '{
        '{0, CFG_FILE_START,     0, CMD_SECTOR,        0, 1, 1, 0, 1, ERR_NONE},
        '{0, CFG_FILE_START,     0, CMD_DISK_ERR, 'h7FFFF, 0, 1, 0, 1, ERR_NONE},
        '{0, CFG_FILE_START,     0, CMD_OTHER,         0, 1, 1, 0, 1, ERR_NONE},
        '{1, CFG_FILE_START,   100, CMD_START,         0, 0, 0, 0, 0, ERR_NONE},
        '{1, CFG_FIRST_SECTOR,   2, CMD_START,         0, 0, 0, 0, 0, ERR_NONE},
        '{1, CFG_LAST_SECTOR,    6, CMD_START,         0, 0, 0, 0, 0, ERR_NONE},
        '{1, CFG_MAX_SECTOR,     8, CMD_START,         0, 0, 0, 0, 0, ERR_NONE},
        '{0, CFG_FILE_START,     0, CMD_START,    'h7FFFF, 1, 1, 1, 0, ERR_NONE},
        '{0, CFG_FILE_START,     0, CMD_SECTOR,      102, 1, 0, 0, 0, ERR_NONE},
        '{0, CFG_FILE_START,     0, CMD_SECTOR,      103, 0, 1, 1, 0, ERR_READ},
        '{0, CFG_FILE_START,     0, CMD_SECTOR,        0, 1, 0, 0, 0, ERR_NONE},
        '{0, CFG_FILE_START,     0, CMD_SECTOR,   'h7FFFF, 1, 0, 0, 0, ERR_NONE},
        '{0, CFG_FILE_START,     0, CMD_DISK_ERR,    103, 1, 1, 1, 0, ERR_DISK},
        '{0, CFG_FILE_START,     0, CMD_OTHER,       103, 1, 1, 1, 0, ERR_UNKNOWN},
        '{0, CFG_FILE_START,     0, CMD_SECTOR,      103, 1, 0, 0, 0, ERR_NONE},
        '{0, CFG_FILE_START,     0, CMD_SECTOR,      104, 1, 0, 0, 0, ERR_NONE},
        '{0, CFG_FILE_START,     0, CMD_SECTOR,      105, 1, 0, 0, 0, ERR_NONE},
        '{0, CFG_FILE_START,     0, CMD_SECTOR,      106, 1, 1, 0, 1, ERR_NONE},
        '{0, CFG_FILE_START,     0, CMD_SECTOR,      106, 1, 1, 0, 1, ERR_NONE},
        '{0, CFG_FILE_START,     0, CMD_START,         0, 0, 0, 0, 0, ERR_NONE},
        '{0, CFG_FILE_START,     0, CMD_SECTOR,      102, 1, 1, 0, 1, ERR_NONE},
        '{1, CFG_LAST_SECTOR, 4095, CMD_START,         0, 0, 0, 0, 0, ERR_NONE},
        '{1, CFG_FIRST_SECTOR,   9, CMD_START,         0, 0, 0, 0, 0, ERR_NONE},
        '{0, CFG_FILE_START,     0, CMD_START,         0, 1, 0, 0, 0, ERR_NONE},
        '{0, CFG_FILE_START,     0, CMD_SECTOR,      109, 1, 1, 1, 0, ERR_OFFSET}
    };

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic [S_TUSER_W-1:0]  s_tuser   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;

    // predictor state and shadow registers
    logic [18:0] base_lba;
    logic [11:0] win_first, win_last, win_max;
    logic        slot_taken [CACHE_SLOTS_DEF];
    logic [7:0]  offset_slot [INDEX_DEPTH_DEF];
    logic [12:0] seek_off;
    logic [19:0] want_lba;
    logic [15:0] retry_run;
    logic        stream_done;
    logic [8:0]  slots_filled;

    fill_result_t fill_results_due [$];

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    int          mismatches     = 0;
    int          items_sent     = 0;
    int          results_checked = 0;
    int          full_hits      = 0;
    int          sat_hits       = 0;
    int          send_mix [4]   = '{0, 79, 0, 27};
    int          recv_mix [4]   = '{0, 0, 79, 27};

    cd_sector_cache_fill u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 aclk = ~aclk;

    function automatic void restart_stream();
        stream_done = 1'b0;
        if (win_last > win_max) win_last = win_max;
        if (seek_off < {1'b0, win_first} || seek_off > {1'b0, win_last})
            seek_off = {1'b0, win_first};
        want_lba = {1'b0, base_lba} + {7'd0, seek_off};
    endfunction

    function automatic fill_result_t predict_fill(cmd_code_t cmd, logic [18:0] lba, logic ok);
        fill_result_t r;
        logic         reissue;
        int           idx;
        int           off;
        int           i;
        r.slot  = 8'd0;
        r.req   = 1'b0;
        r.err   = ERR_NONE;
        reissue = 1'b1;
        if (cmd == CMD_START) begin
            restart_stream();
            r.req = 1'b1;
        end else if (!stream_done) begin
            if (cmd == CMD_SECTOR) begin
                if (int'(slots_filled) >= CACHE_SLOTS_DEF) begin
                    retry_run = 16'd0;
                    r.err     = ERR_FULL;
                end else begin
                    idx = 1;
                    while (idx < CACHE_SLOTS_DEF && slot_taken[idx]) idx++;
                    if (idx >= CACHE_SLOTS_DEF) begin
                        r.err = ERR_FULL;
                    end else if (!ok) begin
                        r.err = ERR_READ;
                    end else if ({1'b0, lba} != want_lba) begin
                        if (retry_run != 16'hFFFF) retry_run = retry_run + 16'd1;
                    end else begin
                        off       = int'(lba) - int'(base_lba);
                        retry_run = 16'd0;
                        if (int'(lba) < int'(base_lba) || off > int'(win_max) ||
                            off >= INDEX_DEPTH_DEF) begin
                            r.err = ERR_OFFSET;
                        end else begin
                            if (offset_slot[off] == 8'd0) begin
                                slots_filled     = slots_filled + 9'd1;
                                slot_taken[idx]  = 1'b1;
                                offset_slot[off] = 8'(idx);
                                r.slot           = 8'(idx);
                            end else begin
                                // already cached: jump to first hole in the window
                                i = off;
                                while (i <= int'(win_last) && i < INDEX_DEPTH_DEF &&
                                       offset_slot[i] != 8'd0) i++;
                                seek_off = 13'(i);
                                if (seek_off > {1'b0, win_last}) stream_done = 1'b1;
                            end
                            if (off == int'(seek_off)) begin
                                seek_off = seek_off + 13'd1;
                                if (seek_off > {1'b0, win_last}) begin
                                    stream_done = 1'b1;
                                end else begin
                                    want_lba = {1'b0, base_lba} + {7'd0, seek_off};
                                    reissue  = 1'b0;
                                end
                            end
                        end
                    end
                end
            end else if (cmd == CMD_DISK_ERR) begin
                r.err = ERR_DISK;
            end else begin
                r.err = ERR_UNKNOWN;
            end
            if (!stream_done && reissue) begin
                restart_stream();
                r.req = 1'b1;
            end
        end
        r.next  = want_lba;
        r.done  = stream_done;
        r.retry = retry_run;
        return r;
    endfunction

    // called only in the step of the last accept or later; lowers s_tvalid itself
    task automatic write_reg(cfg_idx_t sel, logic [18:0] value);
        s_tvalid <= 1'b0;
        while (fill_results_due.size() != 0) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        case (sel)
            CFG_FILE_START:   base_lba  = value;
            CFG_FIRST_SECTOR: win_first = value[11:0];
            CFG_LAST_SECTOR:  win_last  = value[11:0];
            CFG_MAX_SECTOR:   win_max   = value[11:0];
            default: ;
        endcase
    endtask

    task automatic send_item(cmd_code_t cmd, logic [18:0] lba, logic ok);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {4'd0, ok, lba};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        fill_results_due.push_back(predict_fill(cmd, lba, ok));
        items_sent++;
    endtask

    task automatic check_field(string name, logic [19:0] want_v, logic [19:0] got_v);
        if (got_v !== want_v) begin
            $error("%s: expected %0d, got %0d", name, want_v, got_v);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        fill_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (fill_results_due.size() == 0) begin
                $error("result with nothing expected: m_tdata=%h", m_tdata);
                mismatches++;
            end else begin
                want = fill_results_due.pop_front();
                results_checked++;
                if (want.err == ERR_FULL) full_hits++;
                if (want.retry == 16'hFFFF) sat_hits++;
                check_field("store_slot",   20'(want.slot),  20'(m_tdata[7:0]));
                check_field("read_request", 20'(want.req),   20'(m_tdata[8]));
                check_field("next_sector",  want.next,       m_tdata[28:9]);
                check_field("file_done",    20'(want.done),  20'(m_tdata[29]));
                check_field("retry_count",  20'(want.retry), 20'(m_tdata[45:30]));
                check_field("error_code",   20'(want.err),   20'(m_tdata[48:46]));
            end
        end
        m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    initial begin
        cmd_code_t   cmd;
        logic [18:0] lba;
        logic        ok;
        logic [11:0] first_pick;
        logic [11:0] last_pick;
        int          pick;
        int          span;
        int          counted;

        base_lba     = '0;
        win_first    = '0;
        win_last     = '0;
        win_max      = '0;
        foreach (slot_taken[k]) slot_taken[k] = 1'b0;
        slot_taken[0] = 1'b1;
        foreach (offset_slot[k]) offset_slot[k] = 8'd0;
        seek_off     = '0;
        want_lba     = '0;
        retry_run    = '0;
        stream_done  = 1'b1;
        slots_filled = 9'd1;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (plan[n]) begin
            if (plan[n].is_cfg) begin
                write_reg(plan[n].sel, plan[n].value);
            end else begin
                send_item(plan[n].cmd, plan[n].lba, plan[n].ok);
                if (plan[n].typed) begin
                    fill_results_due[$].req  = plan[n].req;
                    fill_results_due[$].done = plan[n].done;
                    fill_results_due[$].err  = plan[n].err;
                end
            end
        end

        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = send_mix[ph];
            recv_stall_pct = recv_mix[ph];

            pick = $urandom_range(0, 9);
            write_reg(CFG_FILE_START, (pick == 0) ? 19'd0 : (pick == 1) ? 19'h7FFFF :
                      (pick < 6) ? 19'($urandom_range(0, 2000)) : 19'($urandom));
            pick = $urandom_range(0, 9);
            first_pick = (pick == 0) ? 12'd0 : (pick == 1) ? 12'd4095 :
                         12'($urandom_range(0, 3000));
            span = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 15) : $urandom_range(0, 4095);
            last_pick = (int'(first_pick) + span > 4095) ? 12'd4095 : 12'(first_pick + span);
            if ($urandom_range(0, 9) == 0) last_pick = 12'($urandom_range(0, 4095));
            write_reg(CFG_FIRST_SECTOR, {7'd0, first_pick});
            write_reg(CFG_LAST_SECTOR, {7'd0, last_pick});
            pick = $urandom_range(0, 9);
            write_reg(CFG_MAX_SECTOR, (pick == 0) ? 19'd0 :
                      (pick == 1) ? 19'($urandom_range(0, 4095)) : 19'd4095);

            counted = 0;
            while (counted < 28) begin
                pick = $urandom_range(0, 99);
                lba  = 19'($urandom);
                ok   = 1'($urandom);
                if (stream_done) begin
                    cmd = (pick < 80) ? CMD_START : cmd_code_t'(2'($urandom_range(1, 3)));
                end else if (pick < 65) begin
                    cmd = CMD_SECTOR;
                    lba = want_lba[18:0];
                    ok  = 1'b1;
                end else if (pick < 75) begin
                    cmd = CMD_SECTOR;
                    lba = want_lba[18:0];
                    ok  = 1'b0;
                end else if (pick < 85) begin
                    cmd = CMD_SECTOR;
                    ok  = 1'b1;
                end else if (pick < 90) begin
                    cmd = CMD_DISK_ERR;
                end else if (pick < 95) begin
                    cmd = CMD_OTHER;
                end else begin
                    cmd = CMD_START;
                end
                if (!stream_done || cmd == CMD_START) counted++;
                send_item(cmd, lba, ok);
            end
        end

        s_tvalid <= 1'b0;
        while (fill_results_due.size() != 0) @(posedge aclk);
        repeat (4200) @(posedge aclk);

        $display("%0d items: directed table, then four random phases of mixed idling",
                 items_sent);
        $display("%0d results checked, %0d slots in use at end, %0d cache-full, %0d saturated",
                 results_checked, slots_filled, full_hits, sat_hits);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
